@@ rtl/ggms_pkg.sv @@
package ggms_pkg;

    // default group size and field widths
    localparam int GROUP_SIZE_DEF = 4;
    localparam int TIME_W         = 32;
    localparam int VALUE_W        = 24;
    localparam int GAP_W          = 32;
    localparam int MEAN_T_W       = 34;
    localparam int MEAN_V_W       = 26;
    localparam int STD_T_W        = 41;
    localparam int STD_V_W        = 33;

    // q.8 deviation means the variance is scaled by 2^16 before the root
    localparam int VAR_SHIFT      = 16;

    localparam logic [GAP_W-1:0] GAP_RESET = 32'd600;

endpackage

@@ rtl/gated_group_mean_stddev.sv @@
// channel   dir  handshake                  payload
// -------   ---  -------------------------  -----------------------------------------
// in        in   i_in_valid / o_in_ready     i_start_curve, i_sample_time, i_sample_value
// out       out  o_out_valid / i_out_ready   o_mean_time, o_mean_value, o_std_time, o_std_value
// cfg       in   i_cfg_we                    i_cfg_data (gap limit)
//
// a word that does not complete a group is taken without leaving the idle state
// a group-completing word starts the sequencer: a sum pass over the store, then per field a
//   mean division, N(N-1)/2 shift-add squares, a variance division and a square root,
//   the divisions and the root at one bit per cycle
// i_rst_n is synchronous, active low; the sample store needs no clearing pass
// while a result waits, any word arriving with the group one short of full stalls
module gated_group_mean_stddev #(
    parameter int GROUP_SIZE = ggms_pkg::GROUP_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic        [ggms_pkg::GAP_W-1:0]   i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_start_curve,
    input  logic        [ggms_pkg::TIME_W-1:0]  i_sample_time,
    input  logic signed [ggms_pkg::VALUE_W-1:0] i_sample_value,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic        [ggms_pkg::MEAN_T_W-1:0] o_mean_time,
    output logic signed [ggms_pkg::MEAN_V_W-1:0] o_mean_value,
    output logic        [ggms_pkg::STD_T_W-1:0] o_std_time,
    output logic        [ggms_pkg::STD_V_W-1:0] o_std_value
);

    localparam int TW    = ggms_pkg::TIME_W;
    localparam int VW    = ggms_pkg::VALUE_W;
    localparam int N     = GROUP_SIZE;
    localparam int IW    = $clog2(N);
    localparam int EW    = TW + VW;                       // one stored sample
    localparam int NPAIR = N * (N - 1) / 2;
    localparam int NN1   = N * (N - 1);                   // divisor n*(n-1)
    localparam int PW    = 2 * TW + $clog2(NPAIR);        // pair sum of squares
    localparam int SW    = PW + ggms_pkg::VAR_SHIFT;      // scaled variance dividend
    localparam int MDW   = TW + 3 + $clog2(N);            // mean dividend
    localparam int RW    = ((SW + 1) / 2 > ggms_pkg::STD_T_W) ? (SW + 1) / 2
                                                              : ggms_pkg::STD_T_W;
    localparam int RMW   = $clog2(NN1) + 1;               // divider remainder
    localparam int CNTW  = $clog2(SW + 1);
    localparam int STW   = TW + $clog2(N);
    localparam int SVW   = VW + $clog2(N);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUM   = 4'd1;
    localparam logic [3:0] S_MLOAD = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_PRD   = 4'd4;
    localparam logic [3:0] S_PWAIT = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_SLOAD = 4'd7;
    localparam logic [3:0] S_SQRT  = 4'd8;

    // control
    logic [3:0]                 r_state;
    logic [ggms_pkg::GAP_W-1:0] r_gap;
    logic [TW-1:0]              r_origin;
    logic [TW-1:0]              r_prev;
    logic [IW-1:0]              r_count;
    logic                       r_out_valid;
    logic                       r_ch;          // 0: time field, 1: value field
    logic                       r_div_std;     // divider runs the variance
    logic [IW-1:0]              r_i;
    logic [IW-1:0]              r_j;
    logic [CNTW-1:0]            r_cnt;

    // datapath
    logic [EW-1:0]              r_mem [N];
    logic [EW-1:0]              r_rd_a;
    logic [EW-1:0]              r_rd_b;
    logic [STW-1:0]             r_sum_t;
    logic signed [SVW-1:0]      r_sum_v;
    logic                       r_neg;
    logic [SW-1:0]              r_dq;
    logic [RMW-1:0]             r_rem;
    logic [RMW-1:0]             r_dvs;
    logic [PW-1:0]              r_psum;
    logic [PW-1:0]              r_mcand;
    logic [TW-1:0]              r_mplier;
    logic [2*RW-1:0]            r_rad;
    logic [RW-1:0]              r_root;
    logic [RW:0]                r_srem;

    logic [ggms_pkg::MEAN_T_W-1:0]  r_mean_time;
    logic signed [ggms_pkg::MEAN_V_W-1:0] r_mean_value;
    logic [ggms_pkg::STD_T_W-1:0]   r_std_time;
    logic [ggms_pkg::STD_V_W-1:0]   r_std_value;

    // input word decode
    logic          w_in_fire;
    logic [TW-1:0] w_rel;
    logic [TW-1:0] w_diff;
    logic          w_take;

    assign o_in_ready = (r_state == S_IDLE) && !(r_out_valid && r_count == IW'(N - 1));
    assign w_in_fire  = i_in_valid && o_in_ready;
    // relative time saturates at zero before the origin
    assign w_rel  = (i_sample_time >= r_origin) ? i_sample_time - r_origin : '0;
    assign w_diff = (w_rel >= r_prev) ? w_rel - r_prev : r_prev - w_rel;
    assign w_take = !i_start_curve && (w_diff < r_gap);

    // read data split
    logic        [TW-1:0] w_ta;
    logic        [TW-1:0] w_tb;
    logic signed [VW-1:0] w_va;
    logic signed [VW-1:0] w_vb;

    assign w_ta = r_rd_a[EW-1:VW];
    assign w_tb = r_rd_b[EW-1:VW];
    assign w_va = r_rd_a[VW-1:0];
    assign w_vb = r_rd_b[VW-1:0];

    // absolute pair difference of the selected field
    logic        [TW-1:0] w_dt;
    logic signed [VW:0]   w_dv;
    logic        [VW:0]   w_dv_neg;
    logic        [VW-1:0] w_dv_mag;
    logic        [TW-1:0] w_d;

    assign w_dt     = (w_ta >= w_tb) ? w_ta - w_tb : w_tb - w_ta;
    assign w_dv     = (VW + 1)'(w_va) - (VW + 1)'(w_vb);
    assign w_dv_neg = '0 - w_dv;
    assign w_dv_mag = w_dv[VW] ? w_dv_neg[VW-1:0] : w_dv[VW-1:0];
    assign w_d      = r_ch ? TW'(w_dv_mag) : w_dt;

    // mean dividend: 4*sum, negative sums rounded toward minus infinity
    logic           w_neg;
    logic [SVW-1:0] w_sv_mag;
    logic [MDW-1:0] w_md;

    assign w_neg    = r_ch && r_sum_v[SVW-1];
    assign w_sv_mag = r_sum_v[SVW-1] ? unsigned'(SVW'(-r_sum_v)) : unsigned'(r_sum_v);
    assign w_md     = r_ch ? MDW'({w_sv_mag, 2'b00}) + (w_neg ? MDW'(N - 1) : MDW'(0))
                           : MDW'({r_sum_t, 2'b00});

    // restoring divider, one quotient bit per cycle
    logic [RMW:0]   n_drn;
    logic           n_dge;
    logic [RMW-1:0] n_rem;
    logic [SW-1:0]  n_dq;

    assign n_drn = {r_rem, r_dq[SW-1]};
    assign n_dge = n_drn >= {1'b0, r_dvs};
    assign n_rem = n_dge ? RMW'(n_drn - {1'b0, r_dvs}) : RMW'(n_drn);
    assign n_dq  = {r_dq[SW-2:0], n_dge};

    // mean result from the finished quotient
    logic [MDW-1:0] w_mq;
    logic [MDW-1:0] w_mq_neg;

    assign w_mq     = n_dq[MDW-1:0];
    assign w_mq_neg = '0 - w_mq;

    // restoring square root, one root bit per cycle
    logic [RW+2:0] n_srn;
    logic [RW+2:0] n_trial;
    logic          n_sge;
    logic [RW:0]   n_srem;
    logic [RW-1:0] n_root;

    assign n_srn   = {r_srem, r_rad[2*RW-1 -: 2]};
    assign n_trial = (RW + 3)'({r_root, 2'b01});
    assign n_sge   = n_srn >= n_trial;
    assign n_srem  = n_sge ? (RW + 1)'(n_srn - n_trial) : (RW + 1)'(n_srn);
    assign n_root  = {r_root[RW-2:0], n_sge};

    // sample store, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_take) begin
            r_mem[r_count] <= {w_rel, i_sample_value};
        end
        r_rd_a <= r_mem[r_i];
        r_rd_b <= r_mem[r_j];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gap       <= ggms_pkg::GAP_RESET;
            r_origin    <= '0;
            r_prev      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_ch        <= 1'b0;
            r_div_std   <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_gap <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        if (i_start_curve) begin
                            r_origin <= i_sample_time;
                            r_prev   <= '0;
                            r_count  <= '0;
                        end else begin
                            r_prev <= w_rel;
                            if (w_take) begin
                                if (r_count == IW'(N - 1)) begin
                                    // group complete: sum both fields first
                                    r_count <= '0;
                                    r_i     <= '0;
                                    r_cnt   <= '0;
                                    r_state <= S_SUM;
                                end else begin
                                    r_count <= r_count + IW'(1);
                                end
                            end
                        end
                    end
                end

                S_SUM: begin
                    // read data comes from a registered port and trails the address
                    r_i   <= r_i + IW'(1);
                    r_cnt <= r_cnt + CNTW'(1);
                    if (r_cnt == CNTW'(N)) begin
                        r_ch    <= 1'b0;
                        r_state <= S_MLOAD;
                    end
                end

                S_MLOAD: begin
                    r_cnt     <= CNTW'(MDW);
                    r_div_std <= 1'b0;
                    r_state   <= S_DIV;
                end

                S_DIV: begin
                    r_cnt <= r_cnt - CNTW'(1);
                    if (r_cnt == CNTW'(1)) begin
                        if (r_div_std) begin
                            r_cnt   <= CNTW'(RW);
                            r_state <= S_SQRT;
                        end else begin
                            r_i     <= '0;
                            r_j     <= IW'(1);
                            r_state <= S_PRD;
                        end
                    end
                end

                S_PRD: begin
                    r_state <= S_PWAIT;
                end

                S_PWAIT: begin
                    r_state <= S_MUL;
                end

                S_MUL: begin
                    // square done once the multiplier runs dry
                    if (r_mplier == '0) begin
                        if (r_j == IW'(N - 1)) begin
                            if (r_i == IW'(N - 2)) begin
                                r_state <= S_SLOAD;
                            end else begin
                                r_i     <= r_i + IW'(1);
                                r_j     <= r_i + IW'(2);
                                r_state <= S_PRD;
                            end
                        end else begin
                            r_j     <= r_j + IW'(1);
                            r_state <= S_PRD;
                        end
                    end
                end

                S_SLOAD: begin
                    r_cnt     <= CNTW'(SW);
                    r_div_std <= 1'b1;
                    r_state   <= S_DIV;
                end

                S_SQRT: begin
                    r_cnt <= r_cnt - CNTW'(1);
                    if (r_cnt == CNTW'(1)) begin
                        if (!r_ch) begin
                            r_ch    <= 1'b1;
                            r_state <= S_MLOAD;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sum_t <= '0;
                r_sum_v <= '0;
            end

            S_SUM: begin
                if (r_cnt != '0) begin
                    r_sum_t <= r_sum_t + STW'(w_ta);
                    r_sum_v <= r_sum_v + SVW'(w_va);
                end
            end

            S_MLOAD: begin
                r_dq  <= {w_md, {(SW - MDW){1'b0}}};
                r_rem <= '0;
                r_dvs <= RMW'(N);
                r_neg <= w_neg;
            end

            S_DIV: begin
                r_dq  <= n_dq;
                r_rem <= n_rem;
                if (r_cnt == CNTW'(1)) begin
                    if (r_div_std) begin
                        r_rad  <= (2 * RW)'(n_dq);
                        r_root <= '0;
                        r_srem <= '0;
                    end else begin
                        r_psum <= '0;
                        if (!r_ch) begin
                            r_mean_time <= w_mq[ggms_pkg::MEAN_T_W-1:0];
                        end else begin
                            r_mean_value <= signed'(r_neg ? w_mq_neg[ggms_pkg::MEAN_V_W-1:0]
                                                          : w_mq[ggms_pkg::MEAN_V_W-1:0]);
                        end
                    end
                end
            end

            S_PWAIT: begin
                r_mcand  <= PW'(w_d);
                r_mplier <= w_d;
            end

            S_MUL: begin
                if (r_mplier[0]) begin
                    r_psum <= r_psum + r_mcand;
                end
                r_mcand  <= {r_mcand[PW-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[TW-1:1]};
            end

            S_SLOAD: begin
                r_dq  <= {r_psum, {ggms_pkg::VAR_SHIFT{1'b0}}};
                r_rem <= '0;
                r_dvs <= RMW'(NN1);
            end

            S_SQRT: begin
                r_rad  <= {r_rad[2*RW-3:0], 2'b00};
                r_root <= n_root;
                r_srem <= n_srem;
                if (r_cnt == CNTW'(1)) begin
                    if (!r_ch) begin
                        r_std_time <= n_root[ggms_pkg::STD_T_W-1:0];
                    end else begin
                        r_std_value <= n_root[ggms_pkg::STD_V_W-1:0];
                    end
                end
            end

            default: begin
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_mean_time  = r_mean_time;
    assign o_mean_value = r_mean_value;
    assign o_std_time   = r_std_time;
    assign o_std_value  = r_std_value;

    // result registers are only rewritten while nothing waits at the output
    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending while the sequencer runs");

    // a result appears only at the end of the second square root
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_SQRT && $past(r_ch)))
        else $error("result raised outside the final root step");

    // divider remainder stays below its divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dvs))
        else $error("divider remainder out of range");

    // group fill never reaches the group size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= IW'(N - 1)))
        else $error("group count out of range");

    // pair indices stay ordered during the square phase
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_PRD || r_state == S_PWAIT) |-> (r_i < r_j))
        else $error("pair indices out of order");

endmodule

@@ verif/gated_group_mean_stddev_tb.sv @@
`timescale 1ns / 1ps

module gated_group_mean_stddev_tb;

    localparam int          GS             = ggms_pkg::GROUP_SIZE_DEF;
    localparam int          TIME_W         = ggms_pkg::TIME_W;
    localparam int          VALUE_W        = ggms_pkg::VALUE_W;
    localparam int          GAP_W          = ggms_pkg::GAP_W;
    localparam int          MEAN_T_W       = ggms_pkg::MEAN_T_W;
    localparam int          MEAN_V_W       = ggms_pkg::MEAN_V_W;
    localparam int          STD_T_W        = ggms_pkg::STD_T_W;
    localparam int          STD_V_W        = ggms_pkg::STD_V_W;
    localparam int          VAR_SHIFT      = ggms_pkg::VAR_SHIFT;
    localparam logic [GAP_W-1:0] GAP_RESET = ggms_pkg::GAP_RESET;
    // long enough for a group result to finish, so this covers any word in flight
    localparam int          SETTLE_CYCLES  = 1000;
    localparam int          TAIL_CYCLES    = 1000;
    localparam int          HOLDOFF_CYCLES = 4000;
    // worst case: every word completes a group and waits out stalls, taken many times over
    localparam int unsigned LIMIT_CYCLES   = 10_000_000;

    typedef struct {
        logic                      start;
        logic [TIME_W-1:0]         stamp;
        logic signed [VALUE_W-1:0] value;
    } t_sample_word;

    typedef struct {
        logic [MEAN_T_W-1:0]        mean_time;
        logic signed [MEAN_V_W-1:0] mean_value;
        logic [STD_T_W-1:0]         std_time;
        logic [STD_V_W-1:0]         std_value;
    } t_group_stats;

    typedef logic signed [63:0] t_group_vec [GS];

    // dut ports, inputs all known from time zero
    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_cfg_we       = 1'b0;
    logic [GAP_W-1:0]            i_cfg_data     = '0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_ready;
    logic                        i_start_curve  = 1'b0;
    logic [TIME_W-1:0]           i_sample_time  = '0;
    logic signed [VALUE_W-1:0]   i_sample_value = '0;
    logic                        o_out_valid;
    logic                        i_out_ready    = 1'b0;
    logic [MEAN_T_W-1:0]         o_mean_time;
    logic signed [MEAN_V_W-1:0]  o_mean_value;
    logic [STD_T_W-1:0]          o_std_time;
    logic [STD_V_W-1:0]          o_std_value;

    // words waiting to be offered, and group results still owed by the block
    t_sample_word word_q [$];
    t_group_stats stats_q [$];
    t_sample_word offered;
    t_group_stats want;

    // predictor state, mirrors the block
    logic [GAP_W-1:0]            gap_m      = GAP_RESET;
    logic [TIME_W-1:0]           origin_m   = '0;
    logic [TIME_W-1:0]           prev_rel_m = '0;
    int unsigned                 count_m    = 0;
    logic [TIME_W-1:0]           t_store [GS];
    logic signed [VALUE_W-1:0]   v_store [GS];

    // idling knobs, changed between phases at the falling edge
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holdoff_asked  = 0;
    int unsigned holdoff_served = 0;
    int unsigned holdoff_left   = 0;

    int unsigned cycle_cnt       = 0;
    int unsigned words_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned gap_writes      = 0;
    int unsigned errors          = 0;

    gated_group_mean_stddev #(
        .GROUP_SIZE     (GS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_start_curve  (i_start_curve),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_mean_time    (o_mean_time),
        .o_mean_value   (o_mean_value),
        .o_std_time     (o_std_time),
        .o_std_value    (o_std_value)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // floor of the exact square root, one root bit per pass
    function automatic logic [63:0] floor_sqrt(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] c;
        int          b;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= x) begin
                r = c;
            end
        end
        return r;
    endfunction

    // q.8 sample deviation: n * ss equals the sum of squared pairwise differences
    function automatic logic [63:0] deviation_q8(t_group_vec x);
        logic [127:0] acc;
        logic [63:0]  d;
        int           i;
        int           j;
        acc = '0;
        for (i = 0; i < GS; i++) begin
            for (j = i + 1; j < GS; j++) begin
                d = (x[i] >= x[j]) ? x[i] - x[j] : x[j] - x[i];
                acc += {64'd0, d} * {64'd0, d};
            end
        end
        acc = (acc << VAR_SHIFT) / 128'(GS * (GS - 1));
        return floor_sqrt(acc);
    endfunction

    // gate one accepted word into the group, queue the stats when it fills
    function void absorb_sample(t_sample_word w);
        logic [TIME_W-1:0]  rel;
        logic [TIME_W-1:0]  diff;
        t_group_vec         tx;
        t_group_vec         vx;
        logic [63:0]        st;
        logic signed [63:0] sv;
        logic signed [63:0] q;
        t_group_stats       r;
        int                 i;
        if (w.start) begin
            origin_m   = w.stamp;
            prev_rel_m = '0;
            count_m    = 0;
            return;
        end
        // times before the origin clamp to zero
        rel        = (w.stamp >= origin_m) ? w.stamp - origin_m : '0;
        diff       = (rel >= prev_rel_m) ? rel - prev_rel_m : prev_rel_m - rel;
        prev_rel_m = rel;
        if (diff < gap_m && count_m < GS) begin
            t_store[count_m] = rel;
            v_store[count_m] = w.value;
            count_m++;
        end
        if (count_m < GS) begin
            return;
        end
        count_m = 0;
        st = '0;
        sv = '0;
        for (i = 0; i < GS; i++) begin
            tx[i] = {32'd0, t_store[i]};
            vx[i] = v_store[i];
            st += {32'd0, t_store[i]};
            sv += vx[i];
        end
        r.mean_time = MEAN_T_W'((st * 4) / GS);
        // floor toward minus infinity for negative sums
        if (sv >= 0) begin
            q = (sv * 4) / GS;
        end else begin
            q = -((-sv * 4 + GS - 1) / GS);
        end
        r.mean_value = q[MEAN_V_W-1:0];
        r.std_time   = STD_T_W'(deviation_q8(tx));
        r.std_value  = STD_V_W'(deviation_q8(vx));
        stats_q.push_back(r);
    endfunction

    function void queue_word(logic s, logic [TIME_W-1:0] t, logic signed [VALUE_W-1:0] v);
        t_sample_word w;
        w.start = s;
        w.stamp = t;
        w.value = v;
        word_q.push_back(w);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            default: return r[VALUE_W-1:0];
        endcase
    endfunction

    // mostly inside the gate window, sometimes exactly on it or far past it
    function automatic logic [TIME_W-1:0] pick_step(logic [GAP_W-1:0] gap);
        case ($urandom_range(15))
            0:       return gap;
            1:       return $urandom;
            2:       return '0;
            default: return (gap == 0) ? '0 : $urandom_range(gap - 1);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_origin();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'hFFFFFFFF - $urandom_range(5000);
            default: return $urandom;
        endcase
    endfunction

    // curves with a start word and random content, mixed with loose noise words
    task automatic queue_random(int n, logic [GAP_W-1:0] gap);
        int                pushed;
        int                len;
        int                k;
        logic [TIME_W-1:0] abs_t;
        logic [TIME_W-1:0] step;
        pushed = 0;
        while (pushed < n) begin
            if ($urandom_range(7) == 0) begin
                queue_word($urandom_range(3) == 0, $urandom, pick_value());
                pushed++;
            end else begin
                abs_t = pick_origin();
                queue_word(1'b1, abs_t, pick_value());
                pushed++;
                len = $urandom_range(12, 4);
                for (k = 0; k < len && pushed < n; k++) begin
                    step = pick_step(gap);
                    if ($urandom_range(3) == 0) begin
                        abs_t -= step;
                    end else begin
                        abs_t += step;
                    end
                    queue_word(1'b0, abs_t, pick_value());
                    pushed++;
                end
            end
        end
    endtask

    // sender stops until every word is taken and every result is back
    task automatic drain();
        while (word_q.size() != 0 || i_in_valid || stats_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_gap(logic [GAP_W-1:0] g);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= g;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        gap_m = g;
        gap_writes++;
        @(negedge i_clk);
    endtask

    task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int n);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random(n, gap_m);
        drain();
    endtask

    // driver: takes the next word once the current one is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                absorb_sample(offered);
                words_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = word_q.pop_front();
                    i_in_valid     <= 1'b1;
                    i_start_curve  <= offered.start;
                    i_sample_time  <= offered.stamp;
                    i_sample_value <= offered.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string fname, logic [STD_T_W-1:0] exp_v,
                               logic [STD_T_W-1:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $display("%0t tb: %s mismatch, expected %h, actual %h",
                     $time, fname, exp_v, got_v);
        end
    endtask

    // monitor: compares each result word with the oldest owed result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (stats_q.size() == 0) begin
                    errors++;
                    $display("%0t tb: result word with nothing expected, actual %h %h %h %h",
                             $time, o_mean_time, o_mean_value, o_std_time, o_std_value);
                end else begin
                    want = stats_q.pop_front();
                    check_field("mean_time", STD_T_W'(want.mean_time), STD_T_W'(o_mean_time));
                    check_field("mean_value", STD_T_W'(unsigned'(want.mean_value)),
                                STD_T_W'(unsigned'(o_mean_value)));
                    check_field("std_time", want.std_time, o_std_time);
                    check_field("std_value", STD_T_W'(want.std_value), STD_T_W'(o_std_value));
                    results_checked++;
                end
            end
            // a long hold-off lets the block fill up and stall its input
            if (holdoff_left != 0) begin
                holdoff_left <= holdoff_left - 1;
                i_out_ready  <= 1'b0;
            end else if (holdoff_served != holdoff_asked) begin
                holdoff_served <= holdoff_asked;
                holdoff_left   <= HOLDOFF_CYCLES;
                i_out_ready    <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset gap limit, no start word yet so times pass unchanged
        queue_word(1'b0, 32'd10, 24'sh7FFFFF);
        queue_word(1'b0, 32'd20, 24'sh800000);
        queue_word(1'b0, 32'd30, 24'sd0);
        queue_word(1'b0, 32'd40, -24'sd1);
        // a start word in the middle of a group empties it
        queue_word(1'b1, 32'd5000, 24'sd0);
        queue_word(1'b0, 32'd5100, 24'sd100);
        queue_word(1'b0, 32'd5200, 24'sd200);
        queue_word(1'b1, 32'd9000, 24'sd0);
        // before the origin, one short of the limit, exactly on it, then collected again
        queue_word(1'b0, 32'd8000, -24'sd5);
        queue_word(1'b0, 32'd9599, 24'sd3);
        queue_word(1'b0, 32'd10199, 24'sd4);
        queue_word(1'b0, 32'd10798, 24'sd7);
        queue_word(1'b0, 32'd10800, 24'sh800000);
        // origin at the top of the range, everything after clamps to zero
        queue_word(1'b1, 32'hFFFFFFFF, 24'sd0);
        queue_word(1'b0, 32'd0, 24'sd1);
        queue_word(1'b0, 32'd100, 24'sd2);
        queue_word(1'b0, 32'hFFFFFFFF, 24'sd3);
        queue_word(1'b0, 32'hFFFFFFFF, -24'sd3);
        run_phase(0, 0, 300);

        // zero limit: nothing is ever collected
        write_gap('0);
        run_phase(0, 0, 60);

        // widest limit with extreme times and values
        write_gap('1);
        queue_word(1'b1, 32'd0, 24'sd0);
        queue_word(1'b0, 32'hFFFFFFFF, 24'sd5);
        queue_word(1'b1, 32'd0, 24'sd0);
        queue_word(1'b0, 32'hFFFFFFFE, 24'sh7FFFFF);
        queue_word(1'b0, 32'd0, 24'sh800000);
        queue_word(1'b0, 32'hFFFFFFFE, 24'sh7FFFFF);
        queue_word(1'b0, 32'd0, 24'sh800000);
        run_phase(72, 0, 300);

        write_gap(32'd1);
        run_phase(0, 72, 200);

        write_gap($urandom_range(100000, 1000));
        run_phase(36, 36, 400);

        // output held off for a long stretch while words keep coming
        write_gap(32'd600);
        holdoff_asked++;
        run_phase(0, 0, 250);

        write_gap($urandom);
        run_phase(0, 72, 300);

        write_gap(32'd3600);
        run_phase(36, 36, 250);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (stats_q.size() != 0) begin
            errors++;
            $display("%0t tb: %0d results never arrived", $time, stats_q.size());
        end

        $display("tb: %0d words in, %0d group results compared, %0d gap limit writes",
                 words_accepted, results_checked, gap_writes);
        $display("tb: idling up to 72 of 100 cycles per side, one long output hold-off");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ggms_pkg.sv
rtl/gated_group_mean_stddev.sv
verif/gated_group_mean_stddev_tb.sv
